// File: hdl/dpsc_pkg.sv
// dpsc_pkg: shared types and constants of the digital pot step controller
// no dependencies; used by the channel interfaces and every module
`default_nettype none

package dpsc_pkg;

   // field widths and table size
   localparam int NUM_CHANNELS = 8;

   typedef logic [2:0] mode_type;
   typedef logic [4:0] step_type;
   typedef logic [5:0] pos_type;
   typedef logic [2:0] chan_type;
   typedef logic [7:0] ms_type;

   // step limits and reset values
   localparam step_type MAX_STEP       = 5'd31;
   localparam pos_type  UNINIT_POS     = 6'(MAX_STEP) + 6'd1;
   localparam chan_type RESET_CHANNEL  = 3'd6;
   localparam ms_type   PULSE_MS_RESET = 8'd60;

   // item modes
   localparam mode_type MODE_TICK    = 3'd0;
   localparam mode_type MODE_UP      = 3'd1;
   localparam mode_type MODE_DOWN    = 3'd2;
   localparam mode_type MODE_SET_SEL = 3'd3;
   localparam mode_type MODE_SET_CH  = 3'd4;
   localparam mode_type MODE_SELECT  = 3'd5;

   // pulse machine
   typedef enum logic [1:0] {
      PS_IDLE,
      PS_UP,
      PS_DOWN
   } pulse_state_type;

   // request word
   typedef struct packed {
      mode_type mode;
      step_type step_value;
      chan_type channel_index;
   } req_word_type;

   // response word
   typedef struct packed {
      logic     up_pulse;
      logic     down_pulse;
      pos_type  wiper_position;
      chan_type active_channel;
      logic     is_ready;
      logic     new_value;
   } rsp_word_type;

   // controller state
   typedef struct packed {
      step_type [NUM_CHANNELS-1:0] targets;
      chan_type                    selected;
      pos_type                     actual;
      pulse_state_type             pulse_state;
      ms_type                      timer;
   } ctrl_state_type;

endpackage

`default_nettype wire

// File: hdl/dpsc_req_if.sv
// dpsc_req_if: request channel, valid/ready with one item word
// depends on dpsc_pkg
`default_nettype none

interface dpsc_req_if;
   import dpsc_pkg::*;

   logic     valid;
   logic     ready;
   mode_type mode;
   step_type step_value;
   chan_type channel_index;

   modport source (output valid, output mode, output step_value, output channel_index,
                   input ready);
   modport sink   (input valid, input mode, input step_value, input channel_index,
                   output ready);
endinterface

`default_nettype wire

// File: hdl/dpsc_rsp_if.sv
// dpsc_rsp_if: response channel, valid/ready with one status word
// depends on dpsc_pkg
`default_nettype none

interface dpsc_rsp_if;
   import dpsc_pkg::*;

   logic     valid;
   logic     ready;
   logic     up_pulse;
   logic     down_pulse;
   pos_type  wiper_position;
   chan_type active_channel;
   logic     is_ready;
   logic     new_value;

   modport source (output valid, output up_pulse, output down_pulse, output wiper_position,
                   output active_channel, output is_ready, output new_value,
                   input ready);
   modport sink   (input valid, input up_pulse, input down_pulse, input wiper_position,
                   input active_channel, input is_ready, input new_value,
                   output ready);
endinterface

`default_nettype wire

// File: hdl/dpsc_step_logic.sv
// dpsc_step_logic: next-state and response logic for one request word
// depends on dpsc_pkg
`default_nettype none

module dpsc_step_logic (
   input  dpsc_pkg::req_word_type   word,
   input  dpsc_pkg::ctrl_state_type cur,
   input  dpsc_pkg::ms_type         pulse_ms,
   output dpsc_pkg::ctrl_state_type nxt,
   output dpsc_pkg::rsp_word_type   rsp
);
   import dpsc_pkg::*;

   step_type tgt;
   step_type clamped;
   logic     done;

   // target of the selected channel and the clamped step value
   assign tgt     = cur.targets[cur.selected];
   assign clamped = (word.step_value > MAX_STEP) ? MAX_STEP : word.step_value;

   // state update per mode
   always_comb begin
      nxt  = cur;
      done = 1'b0;
      unique case (word.mode)
         MODE_TICK: begin
            if (cur.pulse_state != PS_IDLE) begin
               if (cur.timer != 8'd0) begin
                  nxt.timer = cur.timer - 8'd1;
               end else begin
                  if (cur.pulse_state == PS_UP) begin
                     nxt.actual = (cur.actual < 6'(MAX_STEP)) ? cur.actual + 6'd1
                                                              : 6'(MAX_STEP);
                  end else if (cur.actual != 6'd0) begin
                     nxt.actual = cur.actual - 6'd1;
                  end
                  nxt.pulse_state = PS_IDLE;
                  done            = 1'b1;
               end
            end else if ({1'b0, tgt} > cur.actual) begin
               nxt.pulse_state = PS_UP;
               nxt.timer       = pulse_ms;
            end else if ({1'b0, tgt} < cur.actual) begin
               nxt.pulse_state = PS_DOWN;
               nxt.timer       = pulse_ms;
            end
         end
         MODE_UP: begin
            nxt.targets[cur.selected] = (tgt < MAX_STEP) ? tgt + 5'd1 : MAX_STEP;
         end
         MODE_DOWN: begin
            if (tgt != 5'd0) begin
               nxt.targets[cur.selected] = tgt - 5'd1;
            end
         end
         MODE_SET_SEL: begin
            nxt.targets[cur.selected] = clamped;
         end
         MODE_SET_CH: begin
            nxt.targets[word.channel_index] = clamped;
         end
         MODE_SELECT: begin
            nxt.selected = word.channel_index;
         end
         default: begin
         end
      endcase
   end

   // status word from the updated state
   always_comb begin
      rsp.up_pulse       = (nxt.pulse_state == PS_UP);
      rsp.down_pulse     = (nxt.pulse_state == PS_DOWN);
      rsp.wiper_position = nxt.actual;
      rsp.active_channel = nxt.selected;
      rsp.is_ready       = (nxt.actual == 6'd0);
      rsp.new_value      = done;
   end

endmodule

`default_nettype wire

// File: hdl/digital_pot_step_controller_core.sv
// digital_pot_step_controller_core: step controller for an up/down-pulse potentiometer
// depends on dpsc_pkg, dpsc_req_if, dpsc_rsp_if and dpsc_step_logic
//
// Usage: each request word on req_chan is either a millisecond tick or an edit of the
// per-channel target table / selected channel. Every word yields exactly one status word
// on rsp_chan: pulse pins, wiper position, selected channel, ready and new_value flags.
// The pulse hold time is written through csr_write_enable / csr_write_data; the user
// must write it only while the block is idle; the block does not enforce this.
// A running pulse keeps the hold time loaded at its start. An accepted word sits in
// the input register; its status word moves into the response register once that
// register is free, and rsp_chan.valid is driven from the response register.
// Throughput: one word per cycle while rsp_chan is ready.
// Stall: when rsp_chan is not ready the response register holds, the input register
// fills, and req_chan.ready drops; no word is lost or repeated.
// Reset (synchronous, active high): targets all zero, channel 6 selected, wiper 32
// (unknown), pulse machine idle, hold time 60, both channel registers empty.
`default_nettype none

module digital_pot_step_controller_core (
   input  logic             clock,
   input  logic             reset,
   dpsc_req_if.sink         req_chan,
   dpsc_rsp_if.source       rsp_chan,
   input  logic             csr_write_enable,
   input  dpsc_pkg::ms_type csr_write_data
);
   import dpsc_pkg::*;

   logic           in_valid_ff;
   req_word_type   in_word_ff;
   logic           out_valid_ff;
   rsp_word_type   out_word_ff;
   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   rsp_word_type   out_word_in;
   ms_type         pulse_ms_ff;
   logic           out_free;
   logic           advance;
   logic           take;

   // handshake
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign take           = req_chan.valid && req_chan.ready;

   // state update for the word in the input register
   dpsc_step_logic u_step (
      .word     (in_word_ff),
      .cur      (state_ff),
      .pulse_ms (pulse_ms_ff),
      .nxt      (state_in),
      .rsp      (out_word_in)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (take) begin
         in_word_ff.mode          <= req_chan.mode;
         in_word_ff.step_value    <= req_chan.step_value;
         in_word_ff.channel_index <= req_chan.channel_index;
      end
   end

   // controller state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.targets     <= '0;
         state_ff.selected    <= RESET_CHANNEL;
         state_ff.actual      <= UNINIT_POS;
         state_ff.pulse_state <= PS_IDLE;
         state_ff.timer       <= 8'd0;
         out_valid_ff         <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   // hold time register
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ms_ff <= PULSE_MS_RESET;
      end else if (csr_write_enable) begin
         pulse_ms_ff <= csr_write_data;
      end
   end

   // response channel
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.up_pulse       = out_word_ff.up_pulse;
   assign rsp_chan.down_pulse     = out_word_ff.down_pulse;
   assign rsp_chan.wiper_position = out_word_ff.wiper_position;
   assign rsp_chan.active_channel = out_word_ff.active_channel;
   assign rsp_chan.is_ready       = out_word_ff.is_ready;
   assign rsp_chan.new_value      = out_word_ff.new_value;

endmodule

`default_nettype wire

// File: verif/dpsc_checker.sv
// dpsc_checker: watches the request, response and csr ports of the step controller,
// predicts every status word and compares it field by field
// depends on dpsc_pkg, dpsc_req_if and dpsc_rsp_if

module dpsc_checker import dpsc_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   dpsc_req_if    req_mon,
   dpsc_rsp_if    rsp_mon,
   input  logic   csr_write_enable,
   input  ms_type csr_write_data,
   output int     fail_count,
   output int     outstanding,
   output int     words_checked,
   output int     steps_done,
   output int     zero_seen
);

   // shadow of the controller state
   step_type        target_tab [NUM_CHANNELS];
   chan_type        sel_ch;
   pos_type         wiper;
   pulse_state_type pstate;
   ms_type          hold_left;
   ms_type          hold_ms;

   // status words still owed by the block, oldest first
   rsp_word_type    status_q [$];

   // apply one request word to the shadow state and return the status word it yields
   function automatic rsp_word_type apply_word(req_word_type w);
      rsp_word_type s;
      logic         stepped;
      stepped = 1'b0;
      case (w.mode)
         MODE_TICK: begin
            if (pstate != PS_IDLE) begin
               // hold running: count down, then release and move the wiper one step
               if (hold_left != 0) begin
                  hold_left--;
               end else begin
                  if (pstate == PS_UP) begin
                     if (wiper < pos_type'(MAX_STEP)) wiper++;
                     else wiper = pos_type'(MAX_STEP);
                  end else if (wiper != 0) begin
                     wiper--;
                  end
                  pstate  = PS_IDLE;
                  stepped = 1'b1;
               end
            end else if (pos_type'(target_tab[sel_ch]) > wiper) begin
               pstate    = PS_UP;
               hold_left = hold_ms;
            end else if (pos_type'(target_tab[sel_ch]) < wiper) begin
               pstate    = PS_DOWN;
               hold_left = hold_ms;
            end
         end
         MODE_UP: begin
            if (target_tab[sel_ch] < MAX_STEP) target_tab[sel_ch]++;
         end
         MODE_DOWN: begin
            if (target_tab[sel_ch] != 0) target_tab[sel_ch]--;
         end
         MODE_SET_SEL: begin
            target_tab[sel_ch] = (w.step_value > MAX_STEP) ? MAX_STEP : w.step_value;
         end
         MODE_SET_CH: begin
            if (int'(w.channel_index) < NUM_CHANNELS)
               target_tab[w.channel_index] = (w.step_value > MAX_STEP) ? MAX_STEP
                                                                        : w.step_value;
         end
         MODE_SELECT: begin
            if (int'(w.channel_index) < NUM_CHANNELS) sel_ch = w.channel_index;
         end
         default: ;
      endcase
      s.up_pulse       = (pstate == PS_UP);
      s.down_pulse     = (pstate == PS_DOWN);
      s.wiper_position = wiper;
      s.active_channel = sel_ch;
      s.is_ready       = (wiper == 0);
      s.new_value      = stepped;
      return s;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // shadow state update, prediction and comparison at each rising edge
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         foreach (target_tab[i]) target_tab[i] = '0;
         sel_ch        = (int'(RESET_CHANNEL) < NUM_CHANNELS) ? RESET_CHANNEL : '0;
         wiper         = UNINIT_POS;
         pstate        = PS_IDLE;
         hold_left     = '0;
         hold_ms       = PULSE_MS_RESET;
         status_q.delete();
         fail_count    = 0;
         words_checked = 0;
         steps_done    = 0;
         zero_seen     = 0;
      end else begin
         if (csr_write_enable) hold_ms = csr_write_data;
         // response word against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (status_q.size() == 0) begin
               $error("status word with no word expected");
               fail_count++;
            end else begin
               want = status_q.pop_front();
               check_field("up_pulse", want.up_pulse, rsp_mon.up_pulse);
               check_field("down_pulse", want.down_pulse, rsp_mon.down_pulse);
               check_field("wiper_position", want.wiper_position, rsp_mon.wiper_position);
               check_field("active_channel", want.active_channel, rsp_mon.active_channel);
               check_field("is_ready", want.is_ready, rsp_mon.is_ready);
               check_field("new_value", want.new_value, rsp_mon.new_value);
               words_checked++;
               if (want.new_value) steps_done++;
               if (want.is_ready) zero_seen++;
            end
         end
         // accepted request word
         if (req_mon.valid && req_mon.ready)
            status_q.push_back(apply_word({req_mon.mode, req_mon.step_value,
                                           req_mon.channel_index}));
      end
      outstanding = status_q.size();
   end

endmodule

// File: verif/tb_top.sv
// tb_top: stimulus and verdict for digital_pot_step_controller_core
// depends on dpsc_pkg, dpsc_req_if, dpsc_rsp_if, dpsc_checker and the core itself

module tb_top;
   import dpsc_pkg::*;

   localparam int       CYCLE_LIMIT   = 200000;
   localparam int       LONG_HOLD     = 48;
   localparam mode_type MODE_SPARE_LO = 3'd6;
   localparam mode_type MODE_SPARE_HI = 3'd7;

   logic   clock;
   logic   reset;
   logic   csr_write_enable;
   ms_type csr_write_data;

   int     fail_count;
   int     outstanding;
   int     words_checked;
   int     steps_done;
   int     zero_seen;
   int     cycle_count = 0;
   int     hold_requests = 0;
   int     holds_done = 0;
   bit     calm = 1'b0;
   ms_type mid_hold;

   dpsc_req_if req_chan ();
   dpsc_rsp_if rsp_chan ();

   digital_pot_step_controller_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   dpsc_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .words_checked    (words_checked),
      .steps_done       (steps_done),
      .zero_seen        (zero_seen)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // offer one request word after a random gap and wait for its acceptance
   task automatic send_word(mode_type m, step_type s, chan_type c);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.mode          <= m;
      req_chan.step_value    <= s;
      req_chan.channel_index <= c;
      @(posedge clock);
      while (!(req_chan.valid && req_chan.ready)) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and wait until every status word is back
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_hold(ms_type v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // random words, mostly ticks; spare modes are mixed in but not counted
   task automatic run_phase(int count, int tick_pct);
      int       done;
      int       r;
      mode_type m;
      step_type s;
      done = 0;
      while (done < count) begin
         if (done % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < tick_pct) m = MODE_TICK;
         else if (r >= 98) m = mode_type'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         else m = mode_type'($urandom_range(MODE_UP, MODE_SELECT));
         if ($urandom_range(0, 3) == 0) s = $urandom_range(0, 1) ? MAX_STEP : step_type'(0);
         else s = step_type'($urandom_range(0, 31));
         send_word(m, s, chan_type'($urandom_range(0, 7)));
         if (m <= MODE_SELECT) done++;
      end
   endtask

   // result side: random stall per word, long hold on request
   initial begin : rsp_side
      int gap;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (holds_done != hold_requests) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            holds_done++;
         end
         gap = calm ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // stimulus and verdict
   initial begin : req_side
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_write_data         = '0;
      req_chan.valid         = 1'b0;
      req_chan.mode          = MODE_TICK;
      req_chan.step_value    = '0;
      req_chan.channel_index = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: spare modes, field extremes, saturation of target edits
      send_word(MODE_SPARE_LO, 5'd31, 3'd7);
      send_word(MODE_SPARE_HI, 5'd0, 3'd0);
      send_word(MODE_TICK, 5'd0, 3'd0);
      send_word(MODE_SELECT, 5'd0, 3'd0);
      send_word(MODE_SELECT, 5'd31, 3'd7);
      send_word(MODE_SET_CH, 5'd31, 3'd0);
      send_word(MODE_SET_CH, 5'd0, 3'd7);
      send_word(MODE_SET_SEL, 5'd31, 3'd0);
      send_word(MODE_UP, 5'd0, 3'd0);
      send_word(MODE_SET_SEL, 5'd0, 3'd7);
      send_word(MODE_DOWN, 5'd0, 3'd0);
      send_word(MODE_UP, 5'd0, 3'd0);
      send_word(MODE_DOWN, 5'd0, 3'd0);
      send_word(MODE_SELECT, 5'd0, 3'd3);
      send_word(MODE_SET_CH, 5'd21, 3'd5);
      send_word(MODE_SET_SEL, 5'd10, 3'd2);
      send_word(MODE_TICK, 5'd0, 3'd0);
      send_word(MODE_TICK, 5'd0, 3'd0);
      drain();

      // shortest hold written mid pulse; walk the wiper down to zero, then wander
      write_hold(8'd0);
      send_word(MODE_SET_SEL, 5'd0, 3'd0);
      run_phase(180, 100);
      run_phase(170, 60);
      drain();

      // longest hold, dense ticks so a full pulse completes
      write_hold(8'd255);
      run_phase(320, 95);
      drain();

      // receiver holds off twice while words keep coming
      write_hold(8'd3);
      hold_requests++;
      run_phase(125, 60);
      hold_requests++;
      run_phase(125, 60);
      drain();

      // random hold, sender pauses until every word is back
      mid_hold = ms_type'($urandom_range(1, 10));
      write_hold(mid_hold);
      run_phase(100, 65);
      drain();
      run_phase(100, 65);
      drain();

      // walk the wiper up to the top step
      write_hold(8'd1);
      send_word(MODE_SET_SEL, 5'd31, 3'd0);
      run_phase(110, 100);
      run_phase(20, 60);
      drain();

      repeat (8) @(negedge clock);
      $display("checked %0d status words, %0d wiper steps, %0d at position zero",
               words_checked, steps_done, zero_seen);
      $display("hold times used: 60, 0, 255, 3, %0d, 1", mid_hold);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
